### rtl/greedy_box_nms_macros.svh
// assertion macros shared by the checker of the box suppression block
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH

// property held at every clock edge outside reset
`define GBN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a condition in the next
`define GBN_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/gbn_pkg.sv
// types and constants of the box suppression block
package gbn_pkg;

    typedef struct packed {
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] score;
    } box_t;

    typedef struct packed {
        box_t box;
        logic last;
        logic ovf;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_NFLAG,
        ST_NBOX,
        ST_NLOAD,
        ST_SWEEP,
        ST_FLUSH
    } eng_state_t;

    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [15:0] THR_RESET  = 16'd19661;
    // one pixel in Q12.4, the inclusive width term
    localparam logic signed [17:0] PIX_PAD = 18'sd16;

endpackage

### rtl/gbn_res_fifo.sv
// result queue between the suppression engine and the output ports
module gbn_res_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  gbn_pkg::res_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output gbn_pkg::res_t rd_data,
    output logic          empty
);

    gbn_pkg::res_t                 mem_reg [gbn_pkg::FIFO_DEPTH];
    logic [gbn_pkg::FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [gbn_pkg::FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [gbn_pkg::FIFO_AW:0]     cnt_reg, cnt_next;
    logic                          do_wr, do_rd;

    assign full    = (cnt_reg == (gbn_pkg::FIFO_AW+1)'(gbn_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == gbn_pkg::FIFO_AW'(gbn_pkg::FIFO_DEPTH - 1)) ?
                        '0 : wptr_reg + gbn_pkg::FIFO_AW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == gbn_pkg::FIFO_AW'(gbn_pkg::FIFO_DEPTH - 1)) ?
                        '0 : rptr_reg + gbn_pkg::FIFO_AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + (gbn_pkg::FIFO_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - (gbn_pkg::FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/gbn_front.sv
// box loader: counts boxes, drops overflow, closes sets into the job slot
module gbn_front #(
    parameter int   MAX_BOXES = 64,
    localparam int  IW = $clog2(MAX_BOXES),
    localparam int  CW = $clog2(MAX_BOXES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          last_box,
    input  gbn_pkg::box_t in_box,
    output logic          full,
    output logic          st_we,
    output logic [IW-1:0] st_addr,
    output gbn_pkg::box_t st_data,
    output logic          job_valid,
    output logic [CW-1:0] job_count,
    output logic          job_ovf,
    input  logic          job_take,
    input  logic          eng_busy
);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          jobv_reg, jobv_next;
    logic [CW-1:0] jobn_reg, jobn_next;
    logic          jobo_reg, jobo_next;
    logic          accept, store_ok;

    assign full      = jobv_reg || eng_busy;
    assign accept    = push && !full;
    assign store_ok  = (count_reg < CW'(MAX_BOXES));
    assign st_we     = accept && store_ok;
    assign st_addr   = count_reg[IW-1:0];
    assign st_data   = in_box;
    assign job_valid = jobv_reg;
    assign job_count = jobn_reg;
    assign job_ovf   = jobo_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        jobv_next  = jobv_reg;
        jobn_next  = jobn_reg;
        jobo_next  = jobo_reg;
        if (job_take)
        begin
            jobv_next = 1'b0;
        end
        if (accept)
        begin
            if (store_ok)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (last_box)
            begin
                jobv_next  = 1'b1;
                jobn_next  = count_next;
                jobo_next  = ovf_next;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            jobv_reg  <= 1'b0;
            jobo_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            jobv_reg  <= jobv_next;
            jobo_reg  <= jobo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jobn_reg <= jobn_next;
    end

endmodule

### rtl/gbn_engine.sv
// box store, score ranking and pairwise overlap suppression
module gbn_engine #(
    parameter int   MAX_BOXES = 64,
    localparam int  IW = $clog2(MAX_BOXES),
    localparam int  CW = $clog2(MAX_BOXES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    input  logic          st_we,
    input  logic [IW-1:0] st_addr,
    input  gbn_pkg::box_t st_data,
    input  logic          job_valid,
    input  logic [CW-1:0] job_count,
    input  logic          job_ovf,
    output logic          job_take,
    output logic          busy,
    output logic          res_push,
    output gbn_pkg::res_t res_data,
    input  logic          res_full
);

    function automatic logic signed [17:0] ext18(input logic [15:0] v);
        ext18 = $signed({2'b00, v});
    endfunction

    // memories
    gbn_pkg::box_t     store_mem [MAX_BOXES];
    logic [IW-1:0]     rank_mem  [MAX_BOXES];
    gbn_pkg::box_t     rda_reg, rdb_reg;
    logic [IW-1:0]     rank_rd_reg;
    logic              rda_en;
    logic [IW-1:0]     rda_addr, rdb_addr, rank_raddr;
    logic              rank_we;
    logic [IW-1:0]     rank_waddr, rank_wdata;

    // control
    gbn_pkg::eng_state_t state_reg, state_next;
    logic [15:0]       thr_reg;
    logic [CW-1:0]     n_reg, n_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              s1v_reg, s1v_next;
    logic [IW-1:0]     s1j_reg;
    logic [MAX_BOXES-1:0] flags_reg, flags_next;
    logic              pendv_reg, pendv_next;
    gbn_pkg::box_t     pend_reg;
    logic              pend_load;
    logic              issue;
    logic              score_gt;

    // sweep pipeline, stages 1 to 6
    logic [6:1]        pv_reg, pv_next;
    logic [IW-1:0]     pj_reg [1:6];
    logic signed [17:0] s3_w0, s3_h0, s3_w1, s3_h1, s3_iw, s3_ih;
    logic signed [17:0] c_w0, c_h0, c_w1, c_h1, c_iw, c_ih;
    logic [15:0]       c_lx, c_rx, c_ty, c_by;
    logic signed [35:0] s4_inner, s4_a0, s4_a1;
    logic              s4_disj;
    logic [37:0]       s5_uni;
    logic [33:0]       s5_inner;
    logic              s5_disj;
    logic [33:0]       s6_plo, s6_phi, s6_inner;
    logic              s6_bad;
    logic [51:0]       prod, lhs;
    logic              hit;

    assign busy = (state_reg != gbn_pkg::ST_IDLE);

    // overlap datapath
    always_comb
    begin
        c_lx = (rda_reg.x1 > rdb_reg.x1) ? rda_reg.x1 : rdb_reg.x1;
        c_rx = (rda_reg.x2 < rdb_reg.x2) ? rda_reg.x2 : rdb_reg.x2;
        c_ty = (rda_reg.y1 > rdb_reg.y1) ? rda_reg.y1 : rdb_reg.y1;
        c_by = (rda_reg.y2 < rdb_reg.y2) ? rda_reg.y2 : rdb_reg.y2;
        c_w0 = ext18(rda_reg.x2) - ext18(rda_reg.x1) + gbn_pkg::PIX_PAD;
        c_h0 = ext18(rda_reg.y2) - ext18(rda_reg.y1) + gbn_pkg::PIX_PAD;
        c_w1 = ext18(rdb_reg.x2) - ext18(rdb_reg.x1) + gbn_pkg::PIX_PAD;
        c_h1 = ext18(rdb_reg.y2) - ext18(rdb_reg.y1) + gbn_pkg::PIX_PAD;
        c_iw = ext18(c_rx) - ext18(c_lx) + gbn_pkg::PIX_PAD;
        c_ih = ext18(c_by) - ext18(c_ty) + gbn_pkg::PIX_PAD;
    end

    assign prod = {s6_phi, 18'b0} + 52'(s6_plo);
    assign lhs  = {2'b00, s6_inner, 16'b0};
    assign hit  = !s6_bad && (lhs > prod);

    always_ff @(posedge clk)
    begin
        s3_w0    <= c_w0;
        s3_h0    <= c_h0;
        s3_w1    <= c_w1;
        s3_h1    <= c_h1;
        s3_iw    <= c_iw;
        s3_ih    <= c_ih;
        s4_inner <= s3_iw * s3_ih;
        s4_a0    <= s3_w0 * s3_h0;
        s4_a1    <= s3_w1 * s3_h1;
        s4_disj  <= s3_iw[17] || (s3_iw == '0) || s3_ih[17] || (s3_ih == '0);
        s5_uni   <= {{2{s4_a0[35]}}, s4_a0} + {{2{s4_a1[35]}}, s4_a1}
                    - {{2{s4_inner[35]}}, s4_inner};
        s5_inner <= s4_inner[33:0];
        s5_disj  <= s4_disj;
        // union split in two halves for the threshold product
        s6_plo   <= thr_reg * s5_uni[17:0];
        s6_phi   <= thr_reg * s5_uni[35:18];
        s6_inner <= s5_inner;
        s6_bad   <= s5_disj || s5_uni[37] || (s5_uni == '0);
        pj_reg[1] <= j_reg[IW-1:0];
        for (int k = 2; k <= 6; k++)
        begin
            pj_reg[k] <= pj_reg[k-1];
        end
        s1j_reg <= j_reg[IW-1:0];
        if (pend_load)
        begin
            pend_reg <= rda_reg;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_addr] <= st_data;
        end
        if (rda_en)
        begin
            rda_reg <= store_mem[rda_addr];
        end
        rdb_reg <= store_mem[rdb_addr];
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[rank_raddr];
    end

    assign score_gt = (rdb_reg.score > rda_reg.score) ||
                      ((rdb_reg.score == rda_reg.score) && (CW'(s1j_reg) < i_reg));

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        s1v_next   = 1'b0;
        flags_next = flags_reg;
        pendv_next = pendv_reg;
        pend_load  = 1'b0;
        job_take   = 1'b0;
        rda_en     = 1'b0;
        rda_addr   = i_reg[IW-1:0];
        rdb_addr   = j_reg[IW-1:0];
        rank_raddr = i_reg[IW-1:0];
        rank_we    = 1'b0;
        rank_waddr = cnt_reg[IW-1:0];
        rank_wdata = i_reg[IW-1:0];
        res_push   = 1'b0;
        res_data   = '{box: pend_reg, last: 1'b0, ovf: ovf_reg};
        issue      = 1'b0;
        pv_next    = {pv_reg[5:1], 1'b0};
        if (pv_reg[6] && hit)
        begin
            flags_next[pj_reg[6]] = 1'b1;
        end

        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take   = 1'b1;
                    n_next     = job_count;
                    ovf_next   = job_ovf;
                    flags_next = '0;
                    pendv_next = 1'b0;
                    i_next     = '0;
                    j_next     = '0;
                    cnt_next   = '0;
                    state_next = gbn_pkg::ST_SORT;
                end
            end
            gbn_pkg::ST_SORT:
            begin
                // rank of box i: count boxes ahead of it
                rda_en = 1'b1;
                issue  = (j_reg < n_reg);
                if (issue)
                begin
                    j_next   = j_reg + CW'(1);
                    s1v_next = 1'b1;
                end
                if (s1v_reg && score_gt)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (!issue && !s1v_reg)
                begin
                    rank_we  = 1'b1;
                    cnt_next = '0;
                    j_next   = '0;
                    if (i_reg + CW'(1) == n_reg)
                    begin
                        i_next     = '0;
                        state_next = gbn_pkg::ST_NFLAG;
                    end
                    else
                    begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            gbn_pkg::ST_NFLAG:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = gbn_pkg::ST_FLUSH;
                end
                else if (flags_reg[i_reg[IW-1:0]])
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    state_next = gbn_pkg::ST_NBOX;
                end
            end
            gbn_pkg::ST_NBOX:
            begin
                rda_en     = 1'b1;
                rda_addr   = rank_rd_reg;
                state_next = gbn_pkg::ST_NLOAD;
            end
            gbn_pkg::ST_NLOAD:
            begin
                // previous kept box is not the last one: send it now
                if (!(pendv_reg && res_full))
                begin
                    res_push   = pendv_reg;
                    pend_load  = 1'b1;
                    pendv_next = 1'b1;
                    j_next     = i_reg + CW'(1);
                    state_next = gbn_pkg::ST_SWEEP;
                end
            end
            gbn_pkg::ST_SWEEP:
            begin
                issue      = (j_reg < n_reg);
                rank_raddr = j_reg[IW-1:0];
                rdb_addr   = rank_rd_reg;
                if (issue)
                begin
                    j_next = j_reg + CW'(1);
                end
                pv_next[1] = issue;
                if (!issue && (pv_reg == '0))
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = gbn_pkg::ST_NFLAG;
                end
            end
            gbn_pkg::ST_FLUSH:
            begin
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    res_data.last   = 1'b1;
                    pendv_next      = 1'b0;
                    state_next      = gbn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
            thr_reg   <= gbn_pkg::THR_RESET;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            s1v_reg   <= 1'b0;
            flags_reg <= '0;
            pendv_reg <= 1'b0;
            pv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            s1v_reg   <= s1v_next;
            flags_reg <= flags_next;
            pendv_reg <= pendv_next;
            pv_reg    <= pv_next;
        end
    end

endmodule

### rtl/greedy_box_nms.sv
// top level of the greedy box non-maximum suppression block
// Boxes are pushed one per cycle, while full is low, into a store of
// MAX_BOXES entries; boxes beyond capacity are dropped and every result of
// that set carries overflow. The transfer flagged last_box closes the set and
// full then stays high until the set has been processed. Ranking by score
// (descending, ties in arrival order) makes one score compare per cycle
// through the second read port of the box store. Suppression then walks the
// ranked boxes and, for each kept box, runs overlap tests at one per cycle
// against the boxes ranked below it, followed by a drain of the pipeline.
// Kept boxes leave in rank order through a 4 entry result queue, so a slow
// consumer stalls the suppression loop and, while it is held, the input too;
// out_last marks the final kept box of the set. iou_threshold (Q0.16, reset
// 19661) may be written only while the block is idle.
module greedy_box_nms #(
    parameter int MAX_BOXES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        iou_threshold_we,
    input  logic [15:0] iou_threshold,
    input  logic        push,
    output logic        full,
    input  logic [15:0] box_x1,
    input  logic [15:0] box_y1,
    input  logic [15:0] box_x2,
    input  logic [15:0] box_y2,
    input  logic [15:0] box_score,
    input  logic        last_box,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] out_x1,
    output logic [15:0] out_y1,
    output logic [15:0] out_x2,
    output logic [15:0] out_y2,
    output logic [15:0] out_score,
    output logic        out_last,
    output logic        overflow
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    gbn_pkg::box_t in_box;
    gbn_pkg::box_t st_data;
    gbn_pkg::res_t res_data, out_res;
    logic          st_we;
    logic [IW-1:0] st_addr;
    logic          job_valid, job_ovf, job_take, eng_busy;
    logic [CW-1:0] job_count;
    logic          res_push, res_full;

    assign in_box = '{x1: box_x1, y1: box_y1, x2: box_x2, y2: box_y2, score: box_score};

    // front: loads the store and closes sets into a one entry job slot
    gbn_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .last_box  (last_box),
        .in_box    (in_box),
        .full      (full),
        .st_we     (st_we),
        .st_addr   (st_addr),
        .st_data   (st_data),
        .job_valid (job_valid),
        .job_count (job_count),
        .job_ovf   (job_ovf),
        .job_take  (job_take),
        .eng_busy  (eng_busy)
    );

    // back: ranks the set and runs the greedy suppression
    gbn_engine #(.MAX_BOXES(MAX_BOXES)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (iou_threshold_we),
        .cfg_data  (iou_threshold),
        .st_we     (st_we),
        .st_addr   (st_addr),
        .st_data   (st_data),
        .job_valid (job_valid),
        .job_count (job_count),
        .job_ovf   (job_ovf),
        .job_take  (job_take),
        .busy      (eng_busy),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    // result queue decouples the consumer from the suppression loop
    gbn_res_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign out_x1    = out_res.box.x1;
    assign out_y1    = out_res.box.y1;
    assign out_x2    = out_res.box.x2;
    assign out_y2    = out_res.box.y2;
    assign out_score = out_res.box.score;
    assign out_last  = out_res.last;
    assign overflow  = out_res.ovf;

endmodule

### rtl/greedy_box_nms_chk.sv
// port level checker of the box suppression block and its bind
`include "greedy_box_nms_macros.svh"

module greedy_box_nms_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        iou_threshold_we,
    input logic [15:0] iou_threshold,
    input logic        push,
    input logic        full,
    input logic [15:0] box_x1,
    input logic [15:0] box_y1,
    input logic [15:0] box_x2,
    input logic [15:0] box_y2,
    input logic [15:0] box_score,
    input logic        last_box,
    input logic        empty,
    input logic        pop,
    input logic [15:0] out_x1,
    input logic [15:0] out_y1,
    input logic [15:0] out_x2,
    input logic [15:0] out_y2,
    input logic [15:0] out_score,
    input logic        out_last,
    input logic        overflow
);

    // a closed set blocks the input until it has been processed
    `GBN_ASSERT_NEXT(a_last_blocks, push && !full && last_box, full, "input open after last box")

    // results only appear while a set is being processed
    `GBN_ASSERT(a_res_while_busy, $fell(empty) |-> $past(full), "result without a closed set")

    // a waiting result holds until it is taken
    `GBN_ASSERT_NEXT(a_res_hold, !empty && !pop,
        !empty && $stable(out_score) && $stable(out_last) && $stable(overflow),
        "waiting result changed")

endmodule

bind greedy_box_nms greedy_box_nms_chk u_chk (.*);

### tb/sv/nms_checker.sv
// transfer monitor, suppression predictor and result scoreboard for greedy_box_nms
module nms_checker #(
    parameter int NBOX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        iou_threshold_we,
    input  logic [15:0] iou_threshold,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] box_x1,
    input  logic [15:0] box_y1,
    input  logic [15:0] box_x2,
    input  logic [15:0] box_y2,
    input  logic [15:0] box_score,
    input  logic        last_box,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] out_x1,
    input  logic [15:0] out_y1,
    input  logic [15:0] out_x2,
    input  logic [15:0] out_y2,
    input  logic [15:0] out_score,
    input  logic        out_last,
    input  logic        overflow,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    gbn_pkg::box_t held_boxes [NBOX];
    int            held_count;
    logic          dropped;
    logic [15:0]   thr_q;
    gbn_pkg::res_t kept_q[$];

    task automatic mismatch(string what, longint want, longint got);
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
        errors++;
    endtask

    function automatic bit too_close(gbn_pkg::box_t a, gbn_pkg::box_t b, logic [15:0] thr);
        longint w0, h0, w1, h1, iw, ih, inner, uni;
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        ax1 = a.x1; ay1 = a.y1; ax2 = a.x2; ay2 = a.y2;
        bx1 = b.x1; by1 = b.y1; bx2 = b.x2; by2 = b.y2;
        w0 = ax2 - ax1 + 16;
        h0 = ay2 - ay1 + 16;
        w1 = bx2 - bx1 + 16;
        h1 = by2 - by1 + 16;
        iw = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1) + 16;
        ih = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1) + 16;
        if (iw <= 0 || ih <= 0)
            return 1'b0;
        inner = iw * ih;
        uni = w0 * h0 + w1 * h1 - inner;
        if (uni <= 0)
            return 1'b0;
        return inner * 65536 > longint'(thr) * uni;
    endfunction

    // rank by score, then keep greedily and queue the kept boxes
    task automatic suppress_set();
        int            rank [NBOX];
        bit            gone [NBOX];
        int            k;
        int            first;
        gbn_pkg::res_t r;
        for (int i = 0; i < held_count; i++)
        begin
            k = i;
            while (k > 0 && held_boxes[rank[k-1]].score < held_boxes[i].score)
            begin
                rank[k] = rank[k-1];
                k--;
            end
            rank[k] = i;
            gone[i] = 1'b0;
        end
        first = kept_q.size();
        for (int i = 0; i < held_count; i++)
        begin
            if (!gone[i])
            begin
                r.box  = held_boxes[rank[i]];
                r.last = 1'b0;
                r.ovf  = dropped;
                kept_q.insert(kept_q.size(), r);
                for (int j = i + 1; j < held_count; j++)
                    if (!gone[j] && too_close(held_boxes[rank[i]], held_boxes[rank[j]], thr_q))
                        gone[j] = 1'b1;
            end
        end
        if (kept_q.size() > first)
            kept_q[kept_q.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gbn_pkg::res_t want;
        gbn_pkg::box_t b;
        if (!rst_n)
        begin
            held_count = 0;
            dropped    = 1'b0;
            thr_q      = gbn_pkg::THR_RESET;
            errors     = 0;
            kept_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (kept_q.size() == 0)
                begin
                    $display("%0t unexpected result x1=%0h score=%0h", $realtime,
                             out_x1, out_score);
                    errors++;
                end
                else
                begin
                    want = kept_q.pop_front();
                    if (out_x1 !== want.box.x1) mismatch("out_x1", want.box.x1, out_x1);
                    if (out_y1 !== want.box.y1) mismatch("out_y1", want.box.y1, out_y1);
                    if (out_x2 !== want.box.x2) mismatch("out_x2", want.box.x2, out_x2);
                    if (out_y2 !== want.box.y2) mismatch("out_y2", want.box.y2, out_y2);
                    if (out_score !== want.box.score)
                        mismatch("out_score", want.box.score, out_score);
                    if (out_last !== want.last) mismatch("out_last", want.last, out_last);
                    if (overflow !== want.ovf) mismatch("overflow", want.ovf, overflow);
                end
            end
            if (push && !full)
            begin
                b = '{x1: box_x1, y1: box_y1, x2: box_x2, y2: box_y2, score: box_score};
                if (held_count < NBOX)
                begin
                    held_boxes[held_count] = b;
                    held_count++;
                end
                else
                    dropped = 1'b1;
                if (last_box)
                begin
                    suppress_set();
                    held_count = 0;
                    dropped    = 1'b0;
                end
            end
            if (iou_threshold_we)
                thr_q = iou_threshold;
        end
        pending = kept_q.size();
    end

endmodule

### tb/sv/tb_top.sv
// stimulus, handshake pacing and verdict for the greedy_box_nms testbench
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX       = 64;
    // cycles without any transfer before the run is declared hung
    localparam int STUCK_LIMIT = 60000;
    // settle time after the final kept box before a register write or the verdict
    localparam int SETTLE     = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        thr_we = 1'b0;
    logic [15:0] thr_val = '0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] box_x1 = '0, box_y1 = '0, box_x2 = '0, box_y2 = '0, box_score = '0;
    logic        last_box = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] out_x1, out_y1, out_x2, out_y2, out_score;
    logic        out_last, overflow;

    int errors;
    int pending;

    // pacing knobs, percent of cycles spent idle on each side
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    logic hold_go = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    greedy_box_nms #(.MAX_BOXES(NBOX)) uut (
        .clk(clk), .rst_n(rst_n),
        .iou_threshold_we(thr_we), .iou_threshold(thr_val),
        .push(push), .full(full),
        .box_x1(box_x1), .box_y1(box_y1), .box_x2(box_x2), .box_y2(box_y2),
        .box_score(box_score), .last_box(last_box),
        .empty(empty), .pop(pop),
        .out_x1(out_x1), .out_y1(out_y1), .out_x2(out_x2), .out_y2(out_y2),
        .out_score(out_score), .out_last(out_last), .overflow(overflow)
    );

    nms_checker #(.NBOX(NBOX)) chk (
        .clk(clk), .rst_n(rst_n),
        .iou_threshold_we(thr_we), .iou_threshold(thr_val),
        .push(push), .full(full),
        .box_x1(box_x1), .box_y1(box_y1), .box_x2(box_x2), .box_y2(box_y2),
        .box_score(box_score), .last_box(last_box),
        .empty(empty), .pop(pop),
        .out_x1(out_x1), .out_y1(out_y1), .out_x2(out_x2), .out_y2(out_y2),
        .out_score(out_score), .out_last(out_last), .overflow(overflow),
        .errors(errors), .pending(pending)
    );

    // result side: random stalls, plus a long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        pop <= !hold_go && hold_left <= 1 && ($urandom_range(99) >= pop_stall_pct);
    end

    // watchdog on transfers of either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one box, with random idle cycles first, until the transfer happens
    task automatic send_box(gbn_pkg::box_t b, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        box_x1    <= b.x1;
        box_y1    <= b.y1;
        box_x2    <= b.x2;
        box_y2    <= b.y2;
        box_score <= b.score;
        last_box  <= fin;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain_out();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_thr(logic [15:0] v);
        drain_out();
        thr_we  <= 1'b1;
        thr_val <= v;
        @(posedge clk);
        thr_we  <= 1'b0;
    endtask

    function automatic gbn_pkg::box_t rand_box(int spread);
        gbn_pkg::box_t b;
        int            cx, cy;
        if ($urandom_range(4) == 0)
        begin
            // raw fields: any bit pattern, inverted edges included
            b.x1 = 16'($urandom); b.y1 = 16'($urandom);
            b.x2 = 16'($urandom); b.y2 = 16'($urandom);
        end
        else
        begin
            // clustered boxes so that overlap decisions go both ways
            cx = $urandom_range(63000, 2000);
            cy = $urandom_range(63000, 2000);
            cx += int'($urandom_range(2 * spread)) - spread;
            cy += int'($urandom_range(2 * spread)) - spread;
            b.x1 = 16'(cx - int'($urandom_range(1500)));
            b.y1 = 16'(cy - int'($urandom_range(1500)));
            b.x2 = 16'(cx + int'($urandom_range(1500)));
            b.y2 = 16'(cy + int'($urandom_range(1500)));
        end
        // few score values so that ties are common
        b.score = ($urandom_range(2) == 0) ? 16'($urandom_range(3) * 21845) : 16'($urandom);
        return b;
    endfunction

    task automatic send_set(int n);
        int spread;
        spread = $urandom_range(1, 4) * 400;
        for (int i = 0; i < n; i++)
            send_box(rand_box(spread), i == n - 1);
    endtask

    // a short random set, now and then a full or over-full one
    task automatic random_sets(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(19))
                0:       n = NBOX;
                1:       n = NBOX + $urandom_range(1, 3);
                default: n = $urandom_range(1, 10);
            endcase
            if (n > NBOX)
                sent += NBOX;
            else
                sent += n;
            send_set(n);
        end
    endtask

    initial
    begin
        gbn_pkg::box_t b;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identical extreme boxes with a score tie, inverted and
        // degenerate edges, a disjoint box, zero score
        b = '{x1: 16'h0, y1: 16'h0, x2: 16'hFFFF, y2: 16'hFFFF, score: 16'hFFFF};
        send_box(b, 1'b0);
        send_box(b, 1'b0);
        b = '{x1: 16'hFFFF, y1: 16'hFFFF, x2: 16'h0, y2: 16'h0, score: 16'h8000};
        send_box(b, 1'b0);
        b = '{x1: 16'h100, y1: 16'h100, x2: 16'h100, y2: 16'h100, score: 16'h0};
        send_box(b, 1'b0);
        b = '{x1: 16'h0, y1: 16'h0, x2: 16'h10, y2: 16'h10, score: 16'h7FFF};
        send_box(b, 1'b0);
        b = '{x1: 16'h8, y1: 16'h8, x2: 16'h18, y2: 16'h18, score: 16'h7FFF};
        send_box(b, 1'b1);
        // lone box closes a set on its own
        b = '{x1: 16'h1234, y1: 16'h5678, x2: 16'h9ABC, y2: 16'hDEF0, score: 16'h1};
        send_box(b, 1'b1);
        // nested and partly overlapping boxes around the threshold extremes
        write_thr(16'h0);
        for (int i = 0; i < 6; i++)
        begin
            b = '{x1: 16'(i * 40), y1: 16'(i * 40), x2: 16'(400 + i * 40),
                  y2: 16'(400 + i * 40), score: 16'(60000 - i)};
            send_box(b, i == 5);
        end
        write_thr(16'hFFFF);
        for (int i = 0; i < 4; i++)
        begin
            b = '{x1: 16'h200, y1: 16'h200, x2: 16'(16'h300 + (i & 1)), y2: 16'h300,
                  score: 16'(100 + i)};
            send_box(b, i == 3);
        end
        // over-full set whose closing box is itself dropped
        write_thr(gbn_pkg::THR_RESET);
        send_set(NBOX + 1);

        // random part, one idling scheme per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 62; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 62; end
                default: begin send_idle_pct = 14; pop_stall_pct = 14; end
            endcase
            case (ph)
                0: write_thr(16'($urandom_range(65535)));
                1: write_thr(16'h0);
                2: write_thr(16'hFFFF);
                default: write_thr(gbn_pkg::THR_RESET);
            endcase
            random_sets(20);
            if (ph == 1)
            begin
                // long receiver hold-off while sets keep coming, so the result
                // queue fills and the input side backs up
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
                send_set(8);
                send_set(8);
                send_set(3);
            end
            if (ph == 2)
            begin
                // sender waits until every kept box has come out
                push <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
                send_set(5);
            end
        end

        drain_out();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
